// ----- hdl/ffpa_pkg.sv -----
package ffpa_pkg;

	// default pool geometry
	localparam int POOL_PAGES_DEF = 64;
	localparam int PAGE_BYTES_DEF = 4096;

	// request and result field widths
	localparam int BYTES_W  = 19;
	localparam int PAGE_W   = 6;
	localparam int STATUS_W = 2;

	// request function codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		RSP_OK       = 2'd0,
		RSP_EVICTED  = 2'd1,
		RSP_NO_SPACE = 2'd2,
		RSP_BAD_SIZE = 2'd3
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_CHK,
		S_SCAN,
		S_TAKE,
		S_POP,
		S_EVICT,
		S_FCLR,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic chk;
		logic scan_step;
		logic take;
		logic evict;
		logic no_space;
		logic free_clr;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic func;
		logic bad_size;
		logic found;
		logic scan_last;
		logic retry;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/ffpa_ifs.sv -----
// request channel: allocate or free
interface ffpa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [ffpa_pkg::BYTES_W-1:0] request_bytes;
	logic [ffpa_pkg::PAGE_W-1:0]  free_start;

	modport source (output valid, output func, output request_bytes, output free_start,
		input ready);
	modport sink (input valid, input func, input request_bytes, input free_start,
		output ready);
endinterface

// result channel
interface ffpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffpa_pkg::STATUS_W-1:0] status;
	logic [ffpa_pkg::PAGE_W-1:0]   start_page;
	logic [ffpa_pkg::PAGE_W-1:0]   victim_page;

	modport source (output valid, output status, output start_page, output victim_page,
		input ready);
	modport sink (input valid, input status, input start_page, input victim_page,
		output ready);
endinterface

// ----- hdl/ffpa_ram.sv -----
module ffpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ffpa_pkg::POOL_PAGES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/ffpa_ctrl.sv -----
module ffpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ffpa_pkg::sts_t sts,
	output ffpa_pkg::cmd_t cmd
);

	ffpa_pkg::state_t state_q;
	ffpa_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffpa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = ffpa_pkg::S_PREP;
				end
			end
			ffpa_pkg::S_PREP: begin
				if (sts.func == ffpa_pkg::FUNC_FREE) begin
					state_d = ffpa_pkg::S_FCLR;
				end else begin
					state_d = ffpa_pkg::S_CHK;
				end
			end
			ffpa_pkg::S_CHK: begin
				if (sts.bad_size) begin
					state_d = ffpa_pkg::S_DONE;
				end else begin
					state_d = ffpa_pkg::S_SCAN;
				end
			end
			ffpa_pkg::S_SCAN: begin
				if (sts.found) begin
					state_d = ffpa_pkg::S_TAKE;
				end else if (sts.scan_last) begin
					if (sts.retry) begin
						state_d = ffpa_pkg::S_DONE;
					end else begin
						state_d = ffpa_pkg::S_POP;
					end
				end
			end
			ffpa_pkg::S_TAKE: begin
				state_d = ffpa_pkg::S_DONE;
			end
			ffpa_pkg::S_POP: begin
				state_d = ffpa_pkg::S_EVICT;
			end
			ffpa_pkg::S_EVICT: begin
				state_d = ffpa_pkg::S_SCAN;
			end
			ffpa_pkg::S_FCLR: begin
				state_d = ffpa_pkg::S_DONE;
			end
			ffpa_pkg::S_DONE: begin
				if (sts.out_free) begin
					state_d = ffpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffpa_pkg::S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ffpa_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ffpa_pkg::S_CHK: begin
				cmd.chk = 1'b1;
			end
			ffpa_pkg::S_SCAN: begin
				if (!sts.found) begin
					if (!sts.scan_last) begin
						cmd.scan_step = 1'b1;
					end else if (sts.retry) begin
						cmd.no_space = 1'b1;
					end
				end
			end
			ffpa_pkg::S_TAKE: begin
				cmd.take = 1'b1;
			end
			ffpa_pkg::S_EVICT: begin
				cmd.evict = 1'b1;
			end
			ffpa_pkg::S_FCLR: begin
				cmd.free_clr = 1'b1;
			end
			ffpa_pkg::S_DONE: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hdl/ffpa_datapath.sv -----
module ffpa_datapath #(
	parameter int POOL_PAGES = ffpa_pkg::POOL_PAGES_DEF,
	parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffpa_pkg::cmd_t                 cmd,
	output ffpa_pkg::sts_t                 sts,
	input  logic                           in_func,
	input  logic [ffpa_pkg::BYTES_W-1:0]   in_request_bytes,
	input  logic [ffpa_pkg::PAGE_W-1:0]    in_free_start,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [ffpa_pkg::STATUS_W-1:0]  out_status,
	output logic [ffpa_pkg::PAGE_W-1:0]    out_start_page,
	output logic [ffpa_pkg::PAGE_W-1:0]    out_victim_page
);

	// page index, page count and range bound widths
	localparam int PW = $clog2(POOL_PAGES);
	localparam int NW = $clog2(POOL_PAGES + 1);
	localparam int HW = NW + 1;

	// ceiling divide by the page size through a reciprocal
	localparam int XW  = ffpa_pkg::BYTES_W + 1;
	localparam int LW  = $clog2(PAGE_BYTES);
	localparam int SH  = XW + LW;
	localparam int MW  = XW + 1;
	localparam int PRW = XW + MW;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
	localparam logic [MW-1:0] RECIP     = RECIP_FULL[MW-1:0];
	localparam logic [XW-1:0] ROUND_ADD = XW'(PAGE_BYTES - 1);
	localparam logic [PW-1:0] LAST_PAGE = PW'(POOL_PAGES - 1);

	// captured request
	logic                         func_q;
	logic [ffpa_pkg::BYTES_W-1:0] bytes_q;
	logic [ffpa_pkg::PAGE_W-1:0]  fstart_q;

	// size conversion
	logic [XW-1:0]  round_sum;
	logic [PRW-1:0] prod_q;
	logic [PRW-1:0] pages;
	logic [NW-1:0]  n_q;

	// first-fit scan
	logic [PW-1:0] idx_q;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] base_q;
	logic          page_busy;
	logic          retry_q;

	// page bitmap and ring pointers
	logic [POOL_PAGES-1:0] valid_q;
	logic [POOL_PAGES-1:0] valid_d;
	logic [PW-1:0]         head_q;
	logic [PW-1:0]         tail_q;

	// memories
	logic          ring_we;
	logic [PW-1:0] ring_wdata;
	logic [PW-1:0] ring_rd;
	logic [NW-1:0] run_len_rd;

	// run bounds
	logic          fstart_ok;
	logic [HW-1:0] take_lo;
	logic [HW-1:0] take_hi;
	logic [HW-1:0] free_lo;
	logic [HW-1:0] free_hi;

	// result working and output registers
	ffpa_pkg::status_t           res_status_q;
	logic [ffpa_pkg::PAGE_W-1:0] res_start_q;
	logic [ffpa_pkg::PAGE_W-1:0] res_victim_q;
	ffpa_pkg::status_t           out_status_q;
	logic [ffpa_pkg::PAGE_W-1:0] out_start_q;
	logic [ffpa_pkg::PAGE_W-1:0] out_victim_q;
	logic                        out_valid_q;

	// run length per start page
	ffpa_ram #(
		.WIDTH (NW),
		.DEPTH (POOL_PAGES)
	) u_run_len (
		.clk   (clk),
		.we    (cmd.take),
		.waddr (PW'(base_q)),
		.wdata (n_q),
		.raddr (PW'(fstart_q)),
		.rdata (run_len_rd)
	);

	// fifo ring of start pages
	assign ring_we    = (cmd.take && !retry_q) || cmd.evict;
	assign ring_wdata = cmd.evict ? ring_rd : PW'(base_q);

	ffpa_ram #(
		.WIDTH (PW),
		.DEPTH (POOL_PAGES)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (tail_q),
		.wdata (ring_wdata),
		.raddr (head_q),
		.rdata (ring_rd)
	);

	// page count and scan status
	assign round_sum = XW'(bytes_q) + ROUND_ADD;
	assign pages     = prod_q >> SH;
	assign page_busy = valid_q[idx_q];

	assign sts.func      = func_q;
	assign sts.bad_size  = (bytes_q == '0) || (pages > PRW'(POOL_PAGES));
	assign sts.found     = !page_busy && ((HW'(cnt_q) + HW'(1)) == HW'(n_q));
	assign sts.scan_last = (idx_q == LAST_PAGE);
	assign sts.retry     = retry_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	// run bounds for marking and clearing
	assign fstart_ok = int'(fstart_q) < POOL_PAGES;
	assign take_lo   = HW'(base_q);
	assign take_hi   = HW'(base_q) + HW'(n_q);
	assign free_lo   = HW'(fstart_q);
	assign free_hi   = free_lo + HW'(run_len_rd);

	// bitmap update: mark a taken run, clear a freed run or an evicted page
	always_comb begin
		valid_d = valid_q;
		for (int i = 0; i < POOL_PAGES; i++) begin
			if (cmd.take && (HW'(i) >= take_lo) && (HW'(i) < take_hi)) begin
				valid_d[i] = 1'b1;
			end
			if (cmd.free_clr && fstart_ok && (HW'(i) >= free_lo) && (HW'(i) < free_hi)) begin
				valid_d[i] = 1'b0;
			end
		end
		if (cmd.evict) begin
			valid_d[ring_rd] = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			retry_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			if (cmd.evict) begin
				head_q <= (head_q == LAST_PAGE) ? '0 : head_q + 1'b1;
			end
			if (ring_we) begin
				tail_q <= (tail_q == LAST_PAGE) ? '0 : tail_q + 1'b1;
			end
			if (cmd.chk) begin
				retry_q <= 1'b0;
			end else if (cmd.evict) begin
				retry_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, size multiply, scan and results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= in_func;
			bytes_q  <= in_request_bytes;
			fstart_q <= in_free_start;
		end
		prod_q <= {{MW{1'b0}}, round_sum} * {{XW{1'b0}}, RECIP};
		if (cmd.chk) begin
			n_q          <= NW'(pages);
			idx_q        <= '0;
			cnt_q        <= '0;
			base_q       <= '0;
			res_status_q <= ffpa_pkg::RSP_BAD_SIZE;
			res_start_q  <= '0;
			res_victim_q <= '0;
		end
		// one page a cycle: a busy page restarts the candidate run after it
		if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (page_busy) begin
				cnt_q  <= '0;
				base_q <= NW'(idx_q) + NW'(1);
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.take) begin
			res_status_q <= retry_q ? ffpa_pkg::RSP_EVICTED : ffpa_pkg::RSP_OK;
			res_start_q  <= ffpa_pkg::PAGE_W'(base_q);
		end
		// eviction restarts the scan from page zero
		if (cmd.evict) begin
			res_victim_q <= ffpa_pkg::PAGE_W'(ring_rd);
			idx_q        <= '0;
			cnt_q        <= '0;
			base_q       <= '0;
		end
		if (cmd.no_space) begin
			res_status_q <= ffpa_pkg::RSP_NO_SPACE;
		end
		if (cmd.free_clr) begin
			res_status_q <= ffpa_pkg::RSP_OK;
			res_start_q  <= fstart_q;
			res_victim_q <= '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
			out_victim_q <= res_victim_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_start_page  = out_start_q;
	assign out_victim_page = out_victim_q;

endmodule

// ----- hdl/first_fit_page_allocator_fifo_evict.sv -----
// First-fit contiguous page allocator with FIFO eviction over a pool of POOL_PAGES pages of
// PAGE_BYTES bytes. An allocate request rounds its byte size up to a page count and takes the
// lowest free run of that length; when none fits, the oldest start page in the FIFO ring is
// evicted (that single page freed) and the search is retried once. A free request releases the
// run recorded at free_start. One request is worked on at a time. The first-fit search walks
// the page bitmap one page per cycle. A finished result sits in an output register, so the next
// request is taken while it waits. Run lengths and the ring live in two single-port-write RAMs
// with registered reads; neither needs clearing after reset.
module first_fit_page_allocator_fifo_evict #(
	parameter int POOL_PAGES = ffpa_pkg::POOL_PAGES_DEF,
	parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ffpa_req_if.sink   req,
	ffpa_rsp_if.source rsp
);

	ffpa_pkg::cmd_t cmd;
	ffpa_pkg::sts_t sts;

	// sequencer
	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bitmap, ring, run lengths and result register
	ffpa_datapath #(
		.POOL_PAGES (POOL_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_func          (req.func),
		.in_request_bytes (req.request_bytes),
		.in_free_start    (req.free_start),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_status       (rsp.status),
		.out_start_page   (rsp.start_page),
		.out_victim_page  (rsp.victim_page)
	);

endmodule

// ----- tb/first_fit_page_allocator_fifo_evict_tb.sv -----
`timescale 1ns / 1ps

module first_fit_page_allocator_fifo_evict_tb;

	localparam int POOL_PAGES     = ffpa_pkg::POOL_PAGES_DEF;
	localparam int PAGE_BYTES     = ffpa_pkg::PAGE_BYTES_DEF;
	localparam int PAGE_W         = ffpa_pkg::PAGE_W;
	localparam int BYTES_W        = ffpa_pkg::BYTES_W;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 11;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 2 * POOL_PAGES + 16;

	typedef struct packed {
		ffpa_pkg::status_t   status;
		logic [PAGE_W-1:0]   start_page;
		logic [PAGE_W-1:0]   victim_page;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	ffpa_req_if req_if ();
	ffpa_rsp_if rsp_if ();

	first_fit_page_allocator_fifo_evict dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow of the allocator state
	logic        page_valid [POOL_PAGES];
	logic        page_swapped [POOL_PAGES];
	logic [6:0]  run_len [POOL_PAGES];
	logic        len_written [POOL_PAGES];
	logic [PAGE_W-1:0] ring_pages [POOL_PAGES];
	int          ring_head;
	int          ring_tail;
	int          lengths_known;

	alloc_result_t pending_results [$];
	int          err_count;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          hold_req_seq;

	// clock
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	// lowest start of n free pages inside the pool, POOL_PAGES if none
	function automatic int find_free_run(input int n);
		int i;
		int k;
		for (i = 0; i + n <= POOL_PAGES; i++) begin
			for (k = 0; k < n; k++) begin
				if (page_valid[i + k])
					break;
			end
			if (k == n)
				return i;
		end
		return POOL_PAGES;
	endfunction

	function automatic void claim_run(input int s, input int n);
		int k;
		for (k = 0; k < n; k++)
			page_valid[s + k] = 1'b1;
		if (!len_written[s])
			lengths_known++;
		len_written[s] = 1'b1;
		run_len[s] = 7'(n);
	endfunction

	function automatic void ring_push(input int p);
		ring_pages[ring_tail] = PAGE_W'(p);
		ring_tail = (ring_tail + 1) % POOL_PAGES;
	endfunction

	// work out the result of one request and update the shadow state
	function automatic alloc_result_t predict_request(input logic f,
			input logic [BYTES_W-1:0] nbytes, input logic [PAGE_W-1:0] fstart);
		alloc_result_t r;
		int pages;
		int s;
		int v;
		int k;
		r.status      = ffpa_pkg::RSP_OK;
		r.start_page  = '0;
		r.victim_page = '0;
		if (f == ffpa_pkg::FUNC_ALLOC) begin
			pages = (int'(nbytes) + PAGE_BYTES - 1) / PAGE_BYTES;
			if (nbytes == 0 || pages > POOL_PAGES) begin
				r.status = ffpa_pkg::RSP_BAD_SIZE;
			end else begin
				s = find_free_run(pages);
				if (s < POOL_PAGES) begin
					claim_run(s, pages);
					ring_push(s);
					r.start_page = PAGE_W'(s);
				end else begin
					// oldest ring entry goes round again, its page is swapped out
					v = ring_pages[ring_head];
					ring_head = (ring_head + 1) % POOL_PAGES;
					ring_push(v);
					page_valid[v]   = 1'b0;
					page_swapped[v] = 1'b1;
					r.victim_page   = PAGE_W'(v);
					s = find_free_run(pages);
					if (s < POOL_PAGES) begin
						claim_run(s, pages);
						r.status     = ffpa_pkg::RSP_EVICTED;
						r.start_page = PAGE_W'(s);
					end else begin
						r.status = ffpa_pkg::RSP_NO_SPACE;
					end
				end
			end
		end else begin
			r.start_page = fstart;
			for (k = 0; k < int'(run_len[fstart]) && int'(fstart) + k < POOL_PAGES; k++) begin
				page_valid[int'(fstart) + k]   = 1'b0;
				page_swapped[int'(fstart) + k] = 1'b0;
			end
		end
		return r;
	endfunction

	// drive one request, wait for acceptance, queue its expected result
	task automatic send_request(input logic f, input logic [BYTES_W-1:0] nbytes,
			input logic [PAGE_W-1:0] fstart);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.func          <= f;
		req_if.request_bytes <= nbytes;
		req_if.free_start    <= fstart;
		do
			@(posedge clk);
		while (!req_if.ready);
		pending_results.push_back(predict_request(f, nbytes, fstart));
		@(negedge clk);
	endtask

	task automatic send_alloc(input logic [BYTES_W-1:0] nbytes);
		send_request(ffpa_pkg::FUNC_ALLOC, nbytes, PAGE_W'($urandom));
	endtask

	task automatic send_free(input logic [PAGE_W-1:0] p);
		send_request(ffpa_pkg::FUNC_FREE, BYTES_W'($urandom), p);
	endtask

	// sizes mostly small, some large, a few zero or oversize
	function automatic logic [BYTES_W-1:0] random_alloc_bytes();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 8)
			return BYTES_W'($urandom_range(POOL_PAGES * PAGE_BYTES + 1, (1 << BYTES_W) - 1));
		if (pick < 68)
			n = $urandom_range(1, 8);
		else if (pick < 88)
			n = $urandom_range(9, 32);
		else
			n = $urandom_range(33, POOL_PAGES);
		return BYTES_W'($urandom_range((n - 1) * PAGE_BYTES + 1, n * PAGE_BYTES));
	endfunction

	// free a live run start where one turns up, else any page with a known length
	function automatic logic [PAGE_W-1:0] pick_free_page();
		int p;
		int tries;
		for (tries = 0; tries < 8; tries++) begin
			p = $urandom_range(POOL_PAGES - 1);
			if (len_written[p] && page_valid[p])
				return PAGE_W'(p);
		end
		do
			p = $urandom_range(POOL_PAGES - 1);
		while (!len_written[p]);
		return PAGE_W'(p);
	endfunction

	task automatic send_random_item();
		if (lengths_known == 0 || $urandom_range(99) < 55)
			send_alloc(random_alloc_bytes());
		else
			send_free(pick_free_page());
	endtask

	// zero and oversize, first fit into holes, eviction with and without success
	task automatic test_directed();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_alloc('0);
		send_alloc(BYTES_W'(POOL_PAGES * PAGE_BYTES + 1));
		send_alloc(BYTES_W'(1));
		send_alloc(BYTES_W'(PAGE_BYTES));
		send_alloc(BYTES_W'(PAGE_BYTES + 1));
		send_free(PAGE_W'(1));
		send_alloc(BYTES_W'(PAGE_BYTES - 96));
		// whole pool cannot fit: one page evicted, retry still fails
		send_alloc(BYTES_W'(POOL_PAGES * PAGE_BYTES));
		// free of a page already swapped out, then empty the pool
		send_free(PAGE_W'(0));
		send_free(PAGE_W'(1));
		send_free(PAGE_W'(2));
		send_alloc(BYTES_W'(POOL_PAGES * PAGE_BYTES));
		send_alloc(BYTES_W'(2 * PAGE_BYTES));
		send_alloc(BYTES_W'(100));
		// full pool: eviction frees a page inside the big run and the retry fits
		send_alloc(BYTES_W'(1));
		send_free(PAGE_W'(0));
		send_alloc(BYTES_W'((POOL_PAGES - 1) * PAGE_BYTES));
		send_alloc(BYTES_W'(PAGE_BYTES));
		send_free(PAGE_W'(POOL_PAGES - 1));
		send_free(PAGE_W'(0));
		send_alloc(BYTES_W'((1 << BYTES_W) - 1));
	endtask

	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input int stall_pct);
		int i;
		tx_idle_pct  = idle_pct;
		rx_stall_pct = stall_pct;
		for (i = 0; i < n_items; i++)
			send_random_item();
	endtask

	// long receiver hold-off while requests keep coming
	task automatic test_backpressure();
		int i;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req_seq++;
		for (i = 0; i < 24; i++)
			send_random_item();
	endtask

	// result side ready, with random stalls and the long hold-off
	int hold_left;
	int hold_seen_seq;
	always @(negedge clk) begin
		if (hold_seen_seq != hold_req_seq) begin
			hold_seen_seq = hold_req_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", rsp_if.status, -1);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.status !== want.status)
					report_mismatch("status", rsp_if.status, want.status);
				if (rsp_if.start_page !== want.start_page)
					report_mismatch("start_page", rsp_if.start_page, want.start_page);
				if (rsp_if.victim_page !== want.victim_page)
					report_mismatch("victim_page", rsp_if.victim_page, want.victim_page);
			end
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// main sequence
	initial begin
		int i;
		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.func          = ffpa_pkg::FUNC_ALLOC;
		req_if.request_bytes = '0;
		req_if.free_start    = '0;
		err_count            = 0;
		tx_idle_pct          = 0;
		rx_stall_pct         = 0;
		hold_req_seq         = 0;
		ring_head            = 0;
		ring_tail            = 0;
		lengths_known        = 0;
		for (i = 0; i < POOL_PAGES; i++) begin
			page_valid[i]   = 1'b0;
			page_swapped[i] = 1'b0;
			run_len[i]      = '0;
			len_written[i]  = 1'b0;
			ring_pages[i]   = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_traffic(450, 0, 0);
		test_random_traffic(300, 71, 0);
		test_random_traffic(300, 0, 71);
		test_random_traffic(300, 21, 21);
		test_backpressure();
		test_random_traffic(200, 0, 0);
		req_if.valid <= 1'b0;

		// drain, then allow for a stray late result
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ffpa_pkg.sv
hdl/ffpa_ifs.sv
hdl/ffpa_ram.sv
hdl/ffpa_ctrl.sv
hdl/ffpa_datapath.sv
hdl/first_fit_page_allocator_fifo_evict.sv
tb/first_fit_page_allocator_fifo_evict_tb.sv
